// ===== hdl/svi_pkg.sv =====
// Shared types and constants for the sample voice interpolator.
package svi_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AMP_W    = 16;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_END_FRAME     = 3'd1,
    REG_SAMPLE_FRAMES = 3'd2,
    REG_LOOP_BEGIN    = 3'd3,
    REG_LOOP_END      = 3'd4,
    REG_PLAY_MODE     = 3'd5,
    REG_LEFT_GAIN     = 3'd6,
    REG_RIGHT_GAIN    = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_CAP2,
    S_PROD,
    S_INTERP,
    S_AMP,
    S_TSUM,
    S_GAIN,
    S_LANE_OUT,
    S_EMIT,
    S_EMIT_ZERO
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic ram_rd;
    logic rd_next;
    logic lane;
    logic ld_v1;
    logic ld_v2;
    logic ld_prod;
    logic ld_interp;
    logic ld_amp;
    logic ld_t;
    logic ld_gain;
    logic ld_lane;
    logic emit;
    logic emit_zero;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic active;
    logic amp_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/svi_ram.sv =====
// Generic single-port RAM with registered read data.
module svi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/svi_ctrl.sv =====
// Sequencing controller for the sample voice interpolator.
module svi_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  svi_pkg::dp_status_t    status_i,
  output svi_pkg::ctrl_cmd_t     cmd_o
);

  svi_pkg::state_e state_q, state_d;
  logic            lane_q, lane_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svi_pkg::S_IDLE;
      lane_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    unique case (state_q)
      svi_pkg::S_IDLE: begin
        lane_d = 1'b0;
        if (in_valid_i && status_i.is_tick && status_i.active) begin
          state_d = status_i.amp_zero ? svi_pkg::S_EMIT_ZERO : svi_pkg::S_RD1;
        end
      end
      svi_pkg::S_RD1:    state_d = svi_pkg::S_RD2;
      svi_pkg::S_RD2:    state_d = svi_pkg::S_CAP2;
      svi_pkg::S_CAP2:   state_d = svi_pkg::S_PROD;
      svi_pkg::S_PROD:   state_d = svi_pkg::S_INTERP;
      svi_pkg::S_INTERP: state_d = svi_pkg::S_AMP;
      svi_pkg::S_AMP:    state_d = svi_pkg::S_TSUM;
      svi_pkg::S_TSUM:   state_d = svi_pkg::S_GAIN;
      svi_pkg::S_GAIN:   state_d = svi_pkg::S_LANE_OUT;
      svi_pkg::S_LANE_OUT: begin
        if (!lane_q) begin
          lane_d  = 1'b1;
          state_d = svi_pkg::S_RD1;
        end else begin
          state_d = svi_pkg::S_EMIT;
        end
      end
      svi_pkg::S_EMIT, svi_pkg::S_EMIT_ZERO: begin
        if (status_i.out_free) begin
          state_d = svi_pkg::S_IDLE;
        end
      end
      default: state_d = svi_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.lane = lane_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      svi_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      svi_pkg::S_RD1: cmd_o.ram_rd = 1'b1;
      svi_pkg::S_RD2: begin
        cmd_o.ram_rd  = 1'b1;
        cmd_o.rd_next = 1'b1;
        cmd_o.ld_v1   = 1'b1;
      end
      svi_pkg::S_CAP2:     cmd_o.ld_v2     = 1'b1;
      svi_pkg::S_PROD:     cmd_o.ld_prod   = 1'b1;
      svi_pkg::S_INTERP:   cmd_o.ld_interp = 1'b1;
      svi_pkg::S_AMP:      cmd_o.ld_amp    = 1'b1;
      svi_pkg::S_TSUM:     cmd_o.ld_t      = 1'b1;
      svi_pkg::S_GAIN:     cmd_o.ld_gain   = 1'b1;
      svi_pkg::S_LANE_OUT: cmd_o.ld_lane   = 1'b1;
      svi_pkg::S_EMIT:      cmd_o.emit      = status_i.out_free;
      svi_pkg::S_EMIT_ZERO: cmd_o.emit_zero = status_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // a tick on a playing voice must leave idle
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.is_tick && status_i.active) |=> (state_q != svi_pkg::S_IDLE))
    else $error("tick on active voice did not start processing");
`endif

endmodule

// ===== hdl/svi_datapath.sv =====
// Datapath: registers, sample memory, interpolation and scaling arithmetic.
module svi_datapath #(
  parameter int unsigned SAMPLE_WORDS = 65536,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [svi_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [svi_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic [1:0]                            command_i,
  input  logic [15:0]                           address_i,
  input  logic signed [svi_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  logic [svi_pkg::AMP_W-1:0]             envelope_amp_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [svi_pkg::SAMPLE_W-1:0]   left_sample_o,
  output logic signed [svi_pkg::SAMPLE_W-1:0]   right_sample_o,
  output logic                                  voice_active_o,
  input  svi_pkg::ctrl_cmd_t                    cmd_i,
  output svi_pkg::dp_status_t                   status_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned FW = 32 - F;
  localparam int unsigned AW = $clog2(SAMPLE_WORDS);
  localparam int unsigned XW = (AW > FW + 2) ? AW : FW + 2;
  localparam int unsigned XA = (AW > 16) ? AW : 16;
  localparam int unsigned CW = (FW + 1 > 17) ? FW + 1 : 17;
  localparam int unsigned WW = (17 + F > 33) ? 17 + F : 33;
  localparam int unsigned SW = (16 + F > 32) ? 16 + F : 32;
  localparam int unsigned TW = F + 34;

  // Configuration
  logic [23:0] step_q;
  logic [16:0] ef_q, sf_q, le_q;
  logic [15:0] lb_q, lg_q, rg_q;
  logic [1:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 24'd65536;
      ef_q   <= 17'd65536;
      sf_q   <= 17'd65536;
      lb_q   <= 16'd0;
      le_q   <= 17'd65536;
      mode_q <= 2'd0;
      lg_q   <= 16'd32768;
      rg_q   <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svi_pkg::REG_PHASE_STEP:    step_q <= cfg_wdata_i;
        svi_pkg::REG_END_FRAME:     ef_q   <= cfg_wdata_i[16:0];
        svi_pkg::REG_SAMPLE_FRAMES: sf_q   <= cfg_wdata_i[16:0];
        svi_pkg::REG_LOOP_BEGIN:    lb_q   <= cfg_wdata_i[15:0];
        svi_pkg::REG_LOOP_END:      le_q   <= cfg_wdata_i[16:0];
        svi_pkg::REG_PLAY_MODE:     mode_q <= cfg_wdata_i[1:0];
        svi_pkg::REG_LEFT_GAIN:     lg_q   <= cfg_wdata_i[15:0];
        svi_pkg::REG_RIGHT_GAIN:    rg_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic loop_en, stereo;
  assign loop_en = mode_q[0];
  assign stereo  = mode_q[1];

  // Voice state
  logic [31:0] pos_q, pos_d;
  logic        active_q, active_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  logic is_write, is_start, is_tick, is_abort;
  assign is_write = (command_i == svi_pkg::CMD_WRITE);
  assign is_start = (command_i == svi_pkg::CMD_START);
  assign is_tick  = (command_i == svi_pkg::CMD_TICK);
  assign is_abort = (command_i == svi_pkg::CMD_ABORT);

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.is_tick  = is_tick;
  assign status_o.active   = active_q;
  assign status_o.amp_zero = (envelope_amp_i == '0);
  assign status_o.out_free = out_free;

  // Sample memory addressing
  logic [FW-1:0] frame;
  logic [F-1:0]  frac;
  logic [FW:0]   frame_sel;
  logic          in_range;
  logic [XW-1:0] word_x;
  logic [XA-1:0] wr_x;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;
  logic          rd_ok_q;

  assign frame     = pos_q[31:F];
  assign frac      = pos_q[F-1:0];
  assign frame_sel = (FW+1)'(frame) + (FW+1)'(cmd_i.rd_next);
  assign in_range  = CW'(frame_sel) < CW'(sf_q);
  // interleaved: left word first; mono reads lane 0 for both channels
  assign word_x    = stereo ? ((XW'(frame_sel) << 1) | XW'(cmd_i.lane)) : XW'(frame_sel);
  assign wr_x      = XA'(address_i);
  assign ram_we    = cmd_i.accept && is_write;
  assign ram_addr  = ram_we ? wr_x[AW-1:0] : word_x[AW-1:0];

  svi_ram #(
    .WIDTH (svi_pkg::SAMPLE_W),
    .DEPTH (SAMPLE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_value_i),
    .rdata_o (ram_rdata)
  );

  // Arithmetic chain, one register per step
  logic signed [15:0]     v1_q, v2_q, rd_word;
  logic signed [16:0]     diff;
  logic signed [F:0]      frac_s;
  logic signed [F+17:0]   prod_q, prod_d;
  logic signed [F+17:0]   interp_full;
  logic signed [F+15:0]   interp_q;
  logic [15:0]            amp_q;
  logic signed [16:0]     amp_s;
  logic signed [F+16:0]   hi_p_q, hi_p_d;
  logic [31:0]            lo_p_q, lo_p_d;
  logic signed [TW-1:0]   tsum;
  logic signed [31:0]     t_q;
  logic signed [16:0]     gain_s;
  logic signed [48:0]     g_q, g_d;
  logic signed [48:0]     g_rnd;
  logic signed [18:0]     y;
  logic signed [15:0]     y_sat;
  logic signed [15:0]     lane_l_q, lane_r_q;

  assign rd_word     = rd_ok_q ? $signed(ram_rdata) : 16'sd0;
  assign diff        = 17'(v2_q) - 17'(v1_q);
  assign frac_s      = $signed({1'b0, frac});
  assign prod_d      = diff * frac_s;
  assign interp_full = ((F+18)'(v1_q) <<< F) + prod_q;
  assign amp_s       = $signed({1'b0, amp_q});
  assign hi_p_d      = $signed(interp_q[F+15:16]) * amp_s;
  assign lo_p_d      = interp_q[15:0] * amp_q;
  assign tsum        = (TW'(hi_p_q) <<< 16) + $signed(TW'(lo_p_q)) + (TW'(1) <<< (F - 1));
  assign gain_s      = $signed({1'b0, cmd_i.lane ? rg_q : lg_q});
  assign g_d         = t_q * gain_s;
  assign g_rnd       = g_q + (49'sd1 <<< 29);
  assign y           = g_rnd[48:30];

  always_comb begin
    if (y > 19'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -19'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_tick) amp_q <= envelope_amp_i;
    if (cmd_i.ld_v1)     v1_q     <= rd_word;
    if (cmd_i.ld_v2)     v2_q     <= rd_word;
    if (cmd_i.ld_prod)   prod_q   <= prod_d;
    if (cmd_i.ld_interp) interp_q <= interp_full[F+15:0];
    if (cmd_i.ld_amp) begin
      hi_p_q <= hi_p_d;
      lo_p_q <= lo_p_d;
    end
    if (cmd_i.ld_t)      t_q      <= tsum[F+31:F];
    if (cmd_i.ld_gain)   g_q      <= g_d;
    if (cmd_i.ld_lane && !cmd_i.lane) lane_l_q <= y_sat;
    if (cmd_i.ld_lane &&  cmd_i.lane) lane_r_q <= y_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (cmd_i.ram_rd) begin
      rd_ok_q <= in_range;
    end
  end

  // Position advance, loop wrap and end stop
  logic [32:0]   next33;
  logic [WW-1:0] nxt, le_s, ef_s, span_s, lb_s, wrapped;
  logic [SW-1:0] start_w;
  logic          stop;

  assign next33  = {1'b0, pos_q} + 33'(step_q);
  assign nxt     = WW'(next33);
  assign le_s    = WW'(le_q) << F;
  assign ef_s    = WW'(ef_q) << F;
  assign lb_s    = WW'(lb_q) << F;
  assign span_s  = WW'(le_q - 17'(lb_q)) << F;
  assign start_w = SW'(address_i) << F;

  always_comb begin
    wrapped = nxt;
    stop    = 1'b0;
    if (loop_en) begin
      if (nxt >= le_s) begin
        wrapped = (le_q > 17'(lb_q)) ? (nxt - span_s) : lb_s;
      end
    end else if (nxt >= ef_s) begin
      stop = 1'b1;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !out_ready_i;
    priority if (cmd_i.accept && is_start) begin
      pos_d    = start_w[31:0];
      active_d = 1'b1;
    end else if (cmd_i.accept && is_abort) begin
      active_d = 1'b0;
    end else if (cmd_i.emit) begin
      pos_d       = wrapped[31:0];
      active_d    = !stop;
      out_valid_d = 1'b1;
    end else if (cmd_i.emit_zero) begin
      active_d    = 1'b0;
      out_valid_d = 1'b1;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word
  logic signed [15:0] left_q, right_q;
  logic               vact_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      left_q  <= lane_l_q;
      right_q <= lane_r_q;
      vact_q  <= !stop;
    end else if (cmd_i.emit_zero) begin
      left_q  <= '0;
      right_q <= '0;
      vact_q  <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign voice_active_o = vact_q;

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.emit_zero) |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");
  a_rd_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ram_rd |-> !ram_we)
    else $error("sample read collides with a write");
  a_zero_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_zero |=> !active_q)
    else $error("voice still active after zero amplitude tick");
`endif

endmodule

// ===== hdl/sample_voice_interpolator.sv =====
// Top level of the sample voice interpolator: one sampler voice.
//
// Input channel (in_valid_i / in_ready_o) carries one command word:
//   write sample word, start voice, frame tick or abort.
// Output channel (out_valid_o / out_ready_i) carries one result word per
//   frame tick of an active voice: left and right samples and the
//   voice_active flag. Ticks on an idle voice, writes, starts and aborts
//   give no word.
// Write, start and abort words are taken at one per cycle while no tick is
//   in progress. A tick on a playing voice runs two passes (one per channel)
//   through a single-port sample RAM and a chain of registered multiply
//   steps, then loads the output register; the next word is taken after
//   that. A zero amplitude tick skips the passes and loads a zero word.
// The output register holds a finished word while the receiver stalls;
//   input words are still taken then, but a following tick waits in its
//   final step until the output register is free.
// Configuration writes (cfg_we_i) take effect at once; write only while
//   idle. Reset clears position and active flag and loads register
//   defaults; the sample RAM is not cleared and reads of unwritten words
//   return undefined data.
// SAMPLE_WORDS must be a power of two.
module sample_voice_interpolator #(
  parameter int unsigned SAMPLE_WORDS = 65536,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [svi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [svi_pkg::CFG_W-1:0]           cfg_wdata_i,
  // command words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [15:0]                         address_i,
  input  logic signed [svi_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [svi_pkg::AMP_W-1:0]           envelope_amp_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [svi_pkg::SAMPLE_W-1:0] left_sample_o,
  output logic signed [svi_pkg::SAMPLE_W-1:0] right_sample_o,
  output logic                                voice_active_o
);

  svi_pkg::ctrl_cmd_t  cmd;
  svi_pkg::dp_status_t status;

  // sequencer: one step of the tick per state
  svi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // registers, sample RAM and arithmetic
  svi_datapath #(
    .SAMPLE_WORDS (SAMPLE_WORDS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .envelope_amp_i (envelope_amp_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .voice_active_o (voice_active_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

// ===== tb/svi_frame_checker.sv =====
// Frame checker: watches both channels, predicts each result word and compares it.
`timescale 1ns / 1ps

module svi_frame_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [svi_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                command_i,
  input  logic [15:0]               address_i,
  input  logic [15:0]               sample_value_i,
  input  logic [15:0]               envelope_amp_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [15:0]        left_sample_i,
  input  logic signed [15:0]        right_sample_i,
  input  logic                      voice_active_i,
  output int unsigned               mismatches_o,
  output int unsigned               frames_due_o
);

  localparam int unsigned WORDS = 65536;
  localparam int unsigned FRAC  = 16;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               active;
  } frame_t;

  // shadow of the voice registers
  logic [23:0] step_r;
  logic [16:0] stop_r;
  logic [16:0] frames_r;
  logic [15:0] lbeg_r;
  logic [16:0] lend_r;
  logic [1:0]  mode_r;
  logic [15:0] lgain_r;
  logic [15:0] rgain_r;

  logic [15:0] ram [WORDS];
  logic [31:0] pos;
  logic        playing;
  frame_t      expected_frames [$];
  int unsigned mismatches;

  function automatic longint fetch(logic [63:0] frame, int unsigned lane);
    int unsigned chans;
    chans = mode_r[1] ? 2 : 1;
    if (frame >= 64'(frames_r)) return 0;
    return longint'($signed(ram[16'(frame * chans + lane)]));
  endfunction

  function automatic longint blend(logic [63:0] frame, longint frac, int unsigned lane);
    longint v1, v2;
    v1 = fetch(frame, lane);
    v2 = fetch(frame + 64'd1, lane);
    return v1 * (longint'(1) << FRAC) + (v2 - v1) * frac;
  endfunction

  // divide by 2^s, ties towards plus infinity
  function automatic longint round_div(longint x, int unsigned s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] scale(longint mix, logic [15:0] amp, logic [15:0] gain);
    longint t, y;
    t = round_div(mix * longint'(amp), FRAC);
    y = round_div(t * longint'(gain), 30);
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  task automatic voice_tick(logic [15:0] amp);
    frame_t      f;
    logic [63:0] frame, nxt;
    longint      frac, mix_l, mix_r;
    if (playing) begin
      if (amp == 16'd0) begin
        playing = 1'b0;
        f = '0;
      end else begin
        frame = 64'(pos[31:16]);
        frac  = longint'(pos[15:0]);
        mix_l = blend(frame, frac, 0);
        mix_r = mode_r[1] ? blend(frame, frac, 1) : mix_l;
        f.left  = scale(mix_l, amp, lgain_r);
        f.right = scale(mix_r, amp, rgain_r);
        nxt = {32'd0, pos} + 64'(step_r);
        if (mode_r[0]) begin
          if (nxt >= (64'(lend_r) << FRAC)) begin
            if (lend_r > 17'(lbeg_r)) nxt = nxt - (64'(lend_r - 17'(lbeg_r)) << FRAC);
            else nxt = 64'(lbeg_r) << FRAC;
          end
        end else if (nxt >= (64'(stop_r) << FRAC)) begin
          playing = 1'b0;
        end
        pos = nxt[31:0];
        f.active = playing;
      end
      expected_frames.push_back(f);
    end
  endtask

  task automatic compare_frame();
    frame_t want;
    if (expected_frames.size() == 0) begin
      mismatches++;
      $display("%0t: result word with none due (left %0d right %0d active %0b)",
               $time, left_sample_i, right_sample_i, voice_active_i);
    end else begin
      want = expected_frames.pop_front();
      if (left_sample_i !== want.left) begin
        mismatches++;
        $display("%0t: left_sample expected %0d, got %0d", $time, want.left, left_sample_i);
      end
      if (right_sample_i !== want.right) begin
        mismatches++;
        $display("%0t: right_sample expected %0d, got %0d", $time, want.right, right_sample_i);
      end
      if (voice_active_i !== want.active) begin
        mismatches++;
        $display("%0t: voice_active expected %0b, got %0b", $time, want.active, voice_active_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_r   = 24'h010000;
      stop_r   = 17'h10000;
      frames_r = 17'h10000;
      lbeg_r   = 16'h0000;
      lend_r   = 17'h10000;
      mode_r   = 2'b00;
      lgain_r  = 16'h8000;
      rgain_r  = 16'h8000;
      pos      = 32'd0;
      playing  = 1'b0;
      mismatches = 0;
      expected_frames.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_frame();
      if (cfg_we_i) begin
        case (svi_pkg::reg_e'(cfg_idx_i))
          svi_pkg::REG_PHASE_STEP:    step_r   = cfg_wdata_i[23:0];
          svi_pkg::REG_END_FRAME:     stop_r   = cfg_wdata_i[16:0];
          svi_pkg::REG_SAMPLE_FRAMES: frames_r = cfg_wdata_i[16:0];
          svi_pkg::REG_LOOP_BEGIN:    lbeg_r   = cfg_wdata_i[15:0];
          svi_pkg::REG_LOOP_END:      lend_r   = cfg_wdata_i[16:0];
          svi_pkg::REG_PLAY_MODE:     mode_r   = cfg_wdata_i[1:0];
          svi_pkg::REG_LEFT_GAIN:     lgain_r  = cfg_wdata_i[15:0];
          svi_pkg::REG_RIGHT_GAIN:    rgain_r  = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (svi_pkg::cmd_e'(command_i))
          svi_pkg::CMD_WRITE: ram[address_i] = sample_value_i;
          svi_pkg::CMD_START: begin
            pos     = {address_i, 16'h0000};
            playing = 1'b1;
          end
          svi_pkg::CMD_ABORT: playing = 1'b0;
          svi_pkg::CMD_TICK:  voice_tick(envelope_amp_i);
          default: ;
        endcase
      end
    end
    mismatches_o <= mismatches;
    frames_due_o <= expected_frames.size();
  end

endmodule

// ===== tb/tb_sample_voice_interpolator.sv =====
// Top of the sample voice testbench: clock, reset, command and result traffic, verdict.
`timescale 1ns / 1ps

module tb_sample_voice_interpolator;

  localparam int unsigned PREFILL      = 128;     // low words written before any tick
  localparam int unsigned FRAMES_MAX   = PREFILL / 2;
  localparam int unsigned IDLE_PCT     = 29;      // chance of a gap on either side
  localparam int unsigned HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int unsigned SETTLE       = 40;      // lets a trailing tick finish
  localparam int unsigned PHASES       = 10;
  localparam int unsigned DIRECTED     = 22;
  localparam int unsigned RANDOM_WORDS = 350;
  localparam int unsigned STEADY_PHASE = 5;       // no idling on either side
  localparam int unsigned HOLD_PHASE   = 6;       // receiver stalls, block backs up
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    logic [23:0] step;
    logic [16:0] stop_frame;
    logic [16:0] frames;
    logic [15:0] lbeg;
    logic [16:0] lend;
    logic [1:0]  mode;
    logic [15:0] lgain;
    logic [15:0] rgain;
  } voice_cfg_t;

  logic                      clk_i;
  logic                      rst_n;
  logic                      cfg_we;
  svi_pkg::reg_e             cfg_idx;
  logic [svi_pkg::CFG_W-1:0] cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  svi_pkg::cmd_e             command;
  logic [15:0]               address;
  logic signed [15:0]        sample_value;
  logic [15:0]               envelope_amp;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [15:0]        left_sample;
  logic signed [15:0]        right_sample;
  logic                      voice_active;

  int unsigned mismatches;
  int unsigned frames_due;

  // traffic control shared between the sender and the receiver
  int unsigned words_sent;
  bit          src_steady;
  bit          sink_steady;
  int unsigned hold_reqs;

  sample_voice_interpolator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .address_i      (address),
    .sample_value_i (sample_value),
    .envelope_amp_i (envelope_amp),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .left_sample_o  (left_sample),
    .right_sample_o (right_sample),
    .voice_active_o (voice_active)
  );

  svi_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .command_i      (command),
    .address_i      (address),
    .sample_value_i (sample_value),
    .envelope_amp_i (envelope_amp),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .voice_active_i (voice_active),
    .mismatches_o   (mismatches),
    .frames_due_o   (frames_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side. Ready drops at random, except in the steady phase; a
  // hold request from the sender side starts a long stall counted here.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (sink_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one command word and hold it until taken. Valid is left high on
  // return; the next call either keeps it or drops it for a gap, so valid
  // never gets two updates in one step.
  task automatic offer(svi_pkg::cmd_e c, logic [15:0] a, logic [15:0] v, logic [15:0] amp);
    while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= c;
    address      <= a;
    sample_value <= v;
    envelope_amp <= amp;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Fields a command ignores carry noise.
  task automatic write_word(logic [15:0] a, logic [15:0] v);
    offer(svi_pkg::CMD_WRITE, a, v, 16'($urandom));
  endtask

  task automatic start_voice(logic [15:0] frame);
    offer(svi_pkg::CMD_START, frame, 16'($urandom), 16'($urandom));
  endtask

  task automatic tick(logic [15:0] amp);
    offer(svi_pkg::CMD_TICK, 16'($urandom), 16'($urandom), amp);
  endtask

  task automatic abort_voice();
    offer(svi_pkg::CMD_ABORT, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Stop sending, wait for every due frame, then let a trailing idle tick
  // finish before anything touches the registers.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frames_due != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic put_reg(svi_pkg::reg_e r, logic [svi_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk_i);
  endtask

  task automatic program_voice(voice_cfg_t c);
    put_reg(svi_pkg::REG_PHASE_STEP,    c.step);
    put_reg(svi_pkg::REG_END_FRAME,     svi_pkg::CFG_W'(c.stop_frame));
    put_reg(svi_pkg::REG_SAMPLE_FRAMES, svi_pkg::CFG_W'(c.frames));
    put_reg(svi_pkg::REG_LOOP_BEGIN,    svi_pkg::CFG_W'(c.lbeg));
    put_reg(svi_pkg::REG_LOOP_END,      svi_pkg::CFG_W'(c.lend));
    put_reg(svi_pkg::REG_PLAY_MODE,     svi_pkg::CFG_W'(c.mode));
    put_reg(svi_pkg::REG_LEFT_GAIN,     svi_pkg::CFG_W'(c.lgain));
    put_reg(svi_pkg::REG_RIGHT_GAIN,    svi_pkg::CFG_W'(c.rgain));
    cfg_we <= 1'b0;
  endtask

  function automatic voice_cfg_t mk_cfg(logic [23:0] step, logic [16:0] stop_frame,
                                        logic [16:0] frames, logic [15:0] lbeg,
                                        logic [16:0] lend, logic [1:0] mode,
                                        logic [15:0] lgain, logic [15:0] rgain);
    voice_cfg_t c;
    c.step       = step;
    c.stop_frame = stop_frame;
    c.frames     = frames;
    c.lbeg       = lbeg;
    c.lend       = lend;
    c.mode       = mode;
    c.lgain      = lgain;
    c.rgain      = rgain;
    return c;
  endfunction

  function automatic voice_cfg_t random_cfg();
    logic [23:0] step;
    logic [16:0] frames;
    step   = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(24'h030000));
    frames = ($urandom_range(1) == 0) ? 17'($urandom_range(FRAMES_MAX))
                                      : 17'($urandom_range(8, 1));
    return mk_cfg(step, 17'($urandom_range(65536)), frames, 16'($urandom_range(150)),
                  17'($urandom_range(200, 1)), 2'($urandom),
                  16'($urandom_range(32768)), 16'($urandom_range(32768)));
  endfunction

  // Envelope values lean on silence, full scale and the smallest steps.
  function automatic logic [15:0] pick_amp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6)  return 16'h0000;
    if (r < 14) return 16'h8000;
    if (r < 20) return 16'($urandom_range(16, 1));
    return 16'($urandom_range(32768, 1));
  endfunction

  // One note: a start near the region in use, then a run of ticks with the
  // odd abort, restart or sample rewrite mixed in, sometimes a trailing tick.
  task automatic play_phrase(logic [16:0] span);
    int unsigned n;
    int unsigned r;
    if ($urandom_range(4) == 0) start_voice(16'($urandom));
    else start_voice(16'($urandom_range(span)));
    n = $urandom_range(14, 3);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 5) abort_voice();
      else if (r < 11) write_word(16'($urandom_range(2 * span)), 16'($urandom));
      else if (r < 14) start_voice(16'($urandom_range(span)));
      else tick(pick_amp());
    end
    if ($urandom_range(3) == 0) tick(pick_amp());
  endtask

  initial begin : stimulus
    voice_cfg_t  plan [PHASES];
    int unsigned goal;
    logic [16:0] span;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= svi_pkg::REG_PHASE_STEP;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    command      <= svi_pkg::CMD_WRITE;
    address      <= '0;
    sample_value <= '0;
    envelope_amp <= '0;
    sink_steady  <= 1'b0;
    hold_reqs    <= 0;
    src_steady   = 1'b0;
    words_sent   = 0;

    // directed: mono one-shot, step 1.5 frames, stops at frame 8, uneven gains
    plan[0] = mk_cfg(24'h018000, 17'd8, 17'h10000, 16'd0, 17'h10000, 2'b00,
                     16'h8000, 16'h4000);
    // stereo loop over frames 10..40 inside a 64-frame sample
    plan[1] = mk_cfg(24'h00C000, 17'h10000, 17'd64, 16'd10, 17'd40, 2'b11,
                     16'($urandom_range(32768)), 16'($urandom_range(32768)));
    // loop end at or below loop begin: the position jumps to loop begin
    plan[2] = mk_cfg(24'h050000, 17'h10000, 17'(FRAMES_MAX), 16'd50, 17'd20, 2'b01,
                     16'($urandom_range(32768)), 16'($urandom_range(32768)));
    // top extremes: largest step, loop at the very end of the address space
    plan[3] = mk_cfg(24'hFFFFFF, 17'h10000, 17'(FRAMES_MAX), 16'hFFFF, 17'h10000, 2'b11,
                     16'h8000, 16'h8000);
    // bottom extremes: frozen position, stop at frame 0, empty sample, mute
    plan[4] = mk_cfg(24'h000000, 17'd0, 17'd0, 16'd0, 17'd1, 2'b00, 16'h0000, 16'h0000);
    // one-frame loop, mono, fine steps
    plan[5] = mk_cfg(24'($urandom_range(24'h008000, 24'h000001)), 17'h10000,
                     17'(FRAMES_MAX), 16'd0, 17'd1, 2'b01,
                     16'($urandom_range(32768)), 16'($urandom_range(32768)));
    // stereo one-shot running off the sample end before it stops
    plan[6] = mk_cfg(24'($urandom_range(24'h030000, 24'h008000)), 17'd90, 17'd60,
                     16'd0, 17'd1, 2'b10,
                     16'($urandom_range(32768)), 16'($urandom_range(32768)));
    for (int p = 7; p < PHASES; p++) plan[p] = random_cfg();

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    program_voice(plan[0]);

    // The sample RAM powers up undefined, so the low words are written once
    // and sample lengths stay inside them; frames past the length read zero
    // without the RAM. This is also the long gap-free stretch.
    src_steady = 1'b1;
    for (int unsigned a = 0; a < PREFILL; a++) write_word(16'(a), 16'($urandom));
    src_steady = 1'b0;
    words_sent = 0;

    // --- directed part ---
    write_word(16'd0, 16'h7FFF);      // most positive word
    write_word(16'd1, 16'h8000);      // most negative word
    write_word(16'hFFFF, 16'hFFFF);   // top address
    tick(16'h8000);                   // idle voice: no word out
    start_voice(16'd0);
    tick(16'h8000);                   // full scale amplitude, uneven gains
    tick(16'd1);                      // smallest amplitude, half-way blend
    tick(16'h0000);                   // silence: voice drops out
    tick(16'd500);                    // idle again
    start_voice(16'hFFFF);
    tick(16'h8000);                   // next frame lies past the sample end
    start_voice(16'd4);
    tick(16'h8000);
    tick(16'h4000);
    tick(16'h2000);                   // crosses the stop frame
    tick(16'h8000);
    start_voice(16'd2);
    abort_voice();
    tick(16'h8000);                   // aborted voice stays quiet
    start_voice(16'd0);
    tick(16'h8000);                   // rewritten words are seen
    abort_voice();

    // --- random part, one register setting per phase ---
    for (int p = 1; p < PHASES; p++) begin
      quiesce();
      program_voice(plan[p]);
      src_steady = (p == STEADY_PHASE);
      sink_steady <= (p == STEADY_PHASE);
      if (p == HOLD_PHASE) begin
        // receiver stalls while ticks keep coming: output register fills,
        // the next tick parks in its last step and input ready drops
        hold_reqs <= hold_reqs + 1;
        start_voice(16'd0);
        repeat (10) tick(16'h4000);
      end
      span = plan[p].mode[0] ? plan[p].lend : plan[p].stop_frame;
      goal = DIRECTED + (RANDOM_WORDS * p) / (PHASES - 1);
      while (words_sent < goal) play_phrase(span);
    end

    src_steady = 1'b0;
    quiesce();
    if (mismatches == 0 && frames_due == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
